// ===== hdl/stims_pkg.sv =====
`default_nettype none
package stims_pkg;

  // table geometry and field widths
  localparam int SLOT_N = 64;
  localparam int SLOT_W = 6;
  localparam int VAL_W  = 32;
  localparam int ANS_W  = 38;
  localparam int INV_W  = 11;
  localparam int CNT_W  = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // item kinds
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_LOAD  = 2'd0;
  localparam kind_t KIND_PLAY  = 2'd1;
  localparam kind_t KIND_JOIN  = 2'd2;
  localparam kind_t KIND_LEAVE = 2'd3;

  // answer kinds
  typedef logic [1:0] akind_t;
  localparam akind_t AK_NONE = 2'd0;
  localparam akind_t AK_INV  = 2'd1;
  localparam akind_t AK_SUM  = 2'd2;

  // register index (byte address bits above the word offset)
  localparam logic [APB_AW-3:0] REG_SLOTS = '0;

  // shared arithmetic unit
  typedef enum logic {
    ALU_ADD,
    ALU_GT
  } alu_op_t;

  typedef struct packed {
    alu_op_t                  op;
    logic signed [ANS_W-1:0]  a;
    logic signed [ANS_W-1:0]  b;
  } alu_req_t;

  typedef struct packed {
    logic signed [ANS_W-1:0]  sum;
    logic                     gt;
  } alu_res_t;

  function automatic logic signed [ANS_W-1:0] sext_val(input logic signed [VAL_W-1:0] v);
    sext_val = {{(ANS_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/stims_in_if.sv =====
`default_nettype none
interface stims_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            kind;
  logic signed [stims_pkg::VAL_W-1:0]    value;
  logic [stims_pkg::SLOT_W-1:0]          slot;

  modport source (output valid, output kind, output value, output slot, input ready);
  modport sink   (input valid, input kind, input value, input slot, output ready);
endinterface
`default_nettype wire

// ===== hdl/stims_out_if.sv =====
`default_nettype none
interface stims_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [stims_pkg::ANS_W-1:0]    answer;
  logic [1:0]                            answer_kind;
  logic [stims_pkg::CNT_W-1:0]           occupied_count;
  logic                                  error;

  modport source (output valid, output answer, output answer_kind,
                  output occupied_count, output error, input ready);
  modport sink   (input valid, input answer, input answer_kind,
                  input occupied_count, input error, output ready);
endinterface
`default_nettype wire

// ===== hdl/stims_ram.sv =====
`default_nettype none
module stims_ram (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                we,
  input  wire logic [stims_pkg::SLOT_W-1:0]        waddr,
  input  wire logic signed [stims_pkg::VAL_W-1:0]  wdata,
  input  wire logic [stims_pkg::SLOT_W-1:0]        raddr,
  output logic signed [stims_pkg::VAL_W-1:0]       rdata
);
  import stims_pkg::*;

  logic signed [VAL_W-1:0] mem [SLOT_N];
  logic [SLOT_N-1:0]       written;
  logic signed [VAL_W-1:0] rd_q;
  logic                    rd_ok;

  // storage array, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_ok <= written[raddr];
    end
  end

  assign rdata = rd_ok ? rd_q : '0;
endmodule
`default_nettype wire

// ===== hdl/stims_alu.sv =====
`default_nettype none
module stims_alu (
  input  wire stims_pkg::alu_req_t  req,
  output stims_pkg::alu_res_t       res
);
  import stims_pkg::*;

  logic [ANS_W:0] ax;
  logic [ANS_W:0] bx;
  logic [ANS_W:0] r;

  // one 39-bit adder: a + b, or a - b for the signed compare
  always_comb begin
    ax = {req.a[ANS_W-1], req.a};
    bx = {req.b[ANS_W-1], req.b};
    if (req.op == ALU_GT) begin
      r = ax + ~bx + {{ANS_W{1'b0}}, 1'b1};
    end else begin
      r = ax + bx;
    end
    res.sum = r[ANS_W-1:0];
    res.gt  = !r[ANS_W] && (r != '0);
  end
endmodule
`default_nettype wire

// ===== hdl/slot_table_inversion_and_max_subarray.sv =====
`default_nettype none
// Slot table with inversion count and maximum subarray sum.
// item (valid/ready) carries one word per operation: kind, value, slot.
// result (valid/ready) returns exactly one word per item: answer, answer_kind,
// occupied_count, error. The APB port holds slots_in_use at byte address 0.
// One item is worked at a time; item.ready is high only while idle, and the
// finished word sits in an output register, so the next item is taken while
// an earlier word still waits on a stalled receiver.
// Work per item (one shared adder/comparator, one RAM read port):
//   load (not last slot) and leave: straight to the occupancy count
//   join: downward search, then the occupancy count
//   play: two ALU passes per slot, then the count
//   last load: pairwise compare over the RAM, one pair per cycle
//   during each inner scan.
// Every item ends with a pass that counts the occupied flags.
// Reset (rst, synchronous) sets slots_in_use to 64, marks all slots occupied,
// reads all values as zero and restarts the load pointer at slot 0.
module slot_table_inversion_and_max_subarray (
  input  wire logic                               clk,
  input  wire logic                               rst,
  stims_in_if.sink                                item,
  stims_out_if.source                             result,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [stims_pkg::APB_AW-1:0]       paddr,
  input  wire logic [stims_pkg::APB_DW-1:0]       pwdata,
  output logic [stims_pkg::APB_DW-1:0]            prdata,
  output logic                                    pready
);
  import stims_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_INV_J     = 10'b0000000010,
    S_INV_JRD   = 10'b0000000100,
    S_INV_SCAN  = 10'b0000001000,
    S_KAD_FIRST = 10'b0000010000,
    S_KAD_ADD   = 10'b0000100000,
    S_KAD_MAX   = 10'b0001000000,
    S_JOIN      = 10'b0010000000,
    S_COUNT     = 10'b0100000000,
    S_DONE      = 10'b1000000000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        slots_cfg;
  logic [SLOT_W-1:0]       ptr;
  logic [SLOT_N-1:0]       flags;
  logic [SLOT_W-1:0]       idx;
  logic [CNT_W-1:0]        j;
  logic signed [VAL_W-1:0] vj;
  logic signed [VAL_W-1:0] value_r;
  logic signed [ANS_W-1:0] run;
  logic signed [ANS_W-1:0] best;
  logic [INV_W-1:0]        inv;
  logic [CNT_W-1:0]        cnt;
  akind_t                  akind;
  logic                    err;

  logic                    out_valid;
  logic signed [ANS_W-1:0] out_answer;
  akind_t                  out_akind;
  logic [CNT_W-1:0]        out_cnt;
  logic                    out_err;

  logic [CNT_W-1:0]        n;
  logic [SLOT_W-1:0]       last;
  logic                    accept;
  logic                    out_free;
  logic [SLOT_W-1:0]       ptr_eff;
  logic [CNT_W-1:0]        ptr_inc;
  logic                    leave_ok;
  logic                    cfg_wr;

  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic [SLOT_W-1:0]       ram_raddr;
  logic signed [VAL_W-1:0] ram_rdata;

  alu_req_t                alu_req;
  alu_res_t                alu_res;
  logic                    run_pos;
  logic signed [ANS_W-1:0] answer_sel;

  // effective slot count, clamped to 1..SLOT_N
  always_comb begin
    if (slots_cfg == '0) begin
      n = CNT_W'(1);
    end else if (slots_cfg > CNT_W'(SLOT_N)) begin
      n = CNT_W'(SLOT_N);
    end else begin
      n = slots_cfg;
    end
  end
  assign last = SLOT_W'(n - CNT_W'(1));

  assign accept   = item.valid && item.ready;
  assign out_free = !out_valid || result.ready;
  assign ptr_eff  = ({1'b0, ptr} >= n) ? '0 : ptr;
  assign ptr_inc  = {1'b0, ptr_eff} + CNT_W'(1);
  assign leave_ok = {1'b0, item.slot} < n;
  assign run_pos  = !run[ANS_W-1] && (run != '0);

  // APB register
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[APB_AW-1:2] == REG_SLOTS);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1:2] == REG_SLOTS) ?
                  {{(APB_DW-CNT_W){1'b0}}, slots_cfg} : '0;

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_eff;
    ram_wdata = item.value;
    if (state == S_IDLE && accept) begin
      if (item.kind == KIND_LOAD) begin
        ram_we = 1'b1;
      end else if (item.kind == KIND_LEAVE && leave_ok) begin
        ram_we    = 1'b1;
        ram_waddr = item.slot;
        ram_wdata = '0;
      end
    end else if (state == S_JOIN && !flags[idx]) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = value_r;
    end
  end

  // RAM read address, set in the cycle before its data is used
  always_comb begin
    unique case (state)
      S_IDLE:      ram_raddr = '0;
      S_INV_J:     ram_raddr = j[SLOT_W-1:0];
      S_INV_JRD:   ram_raddr = '0;
      S_INV_SCAN:  ram_raddr = idx + SLOT_W'(1);
      S_KAD_FIRST: ram_raddr = SLOT_W'(1);
      S_KAD_MAX:   ram_raddr = idx + SLOT_W'(1);
      default:     ram_raddr = idx;
    endcase
  end

  // shared unit operands
  always_comb begin
    alu_req.op = ALU_GT;
    alu_req.a  = sext_val(ram_rdata);
    alu_req.b  = sext_val(vj);
    if (state == S_KAD_ADD) begin
      alu_req.op = ALU_ADD;
      alu_req.a  = run;
      alu_req.b  = sext_val(ram_rdata);
    end else if (state == S_KAD_MAX) begin
      alu_req.a  = run;
      alu_req.b  = best;
    end
  end

  always_comb begin
    case (akind)
      AK_INV:  answer_sel = {{(ANS_W-INV_W){1'b0}}, inv};
      AK_SUM:  answer_sel = best;
      default: answer_sel = '0;
    endcase
  end

  stims_ram u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  stims_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      slots_cfg <= CNT_W'(SLOT_N);
      ptr       <= '0;
      flags     <= '1;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr) begin
        slots_cfg <= pwdata[CNT_W-1:0];
      end
      // output word: loaded when done, dropped once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cnt <= '0;
            unique case (item.kind)
              KIND_LOAD: begin
                err <= 1'b0;
                idx <= '0;
                if (ptr_inc >= n) begin
                  ptr   <= '0;
                  akind <= AK_INV;
                  j     <= CNT_W'(1);
                  inv   <= '0;
                  state <= S_INV_J;
                end else begin
                  ptr   <= ptr_inc[SLOT_W-1:0];
                  akind <= AK_NONE;
                  state <= S_COUNT;
                end
              end
              KIND_PLAY: begin
                err   <= 1'b0;
                akind <= AK_SUM;
                idx   <= '0;
                state <= S_KAD_FIRST;
              end
              KIND_JOIN: begin
                err     <= 1'b0;
                akind   <= AK_NONE;
                value_r <= item.value;
                idx     <= last;
                state   <= S_JOIN;
              end
              KIND_LEAVE: begin
                akind <= AK_NONE;
                idx   <= '0;
                if (leave_ok) begin
                  flags[item.slot] <= 1'b0;
                  err              <= 1'b0;
                end else begin
                  err <= 1'b1;
                end
                state <= S_COUNT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end

        // outer index: next occupied slot j
        S_INV_J: begin
          if (j >= n) begin
            idx   <= '0;
            cnt   <= '0;
            state <= S_COUNT;
          end else if (flags[j[SLOT_W-1:0]]) begin
            state <= S_INV_JRD;
          end else begin
            j <= j + CNT_W'(1);
          end
        end

        S_INV_JRD: begin
          vj    <= ram_rdata;
          idx   <= '0;
          state <= S_INV_SCAN;
        end

        // inner scan over slots below j
        S_INV_SCAN: begin
          if (flags[idx] && alu_res.gt) begin
            inv <= inv + INV_W'(1);
          end
          if ({1'b0, idx} == j - CNT_W'(1)) begin
            j     <= j + CNT_W'(1);
            state <= S_INV_J;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_KAD_FIRST: begin
          run  <= sext_val(ram_rdata);
          best <= sext_val(ram_rdata);
          if (last == '0) begin
            idx   <= '0;
            cnt   <= '0;
            state <= S_COUNT;
          end else begin
            idx   <= SLOT_W'(1);
            state <= S_KAD_ADD;
          end
        end

        S_KAD_ADD: begin
          run   <= run_pos ? alu_res.sum : sext_val(ram_rdata);
          state <= S_KAD_MAX;
        end

        S_KAD_MAX: begin
          if (alu_res.gt) begin
            best <= run;
          end
          if (idx == last) begin
            idx   <= '0;
            cnt   <= '0;
            state <= S_COUNT;
          end else begin
            idx   <= idx + SLOT_W'(1);
            state <= S_KAD_ADD;
          end
        end

        // downward search for the highest free slot
        S_JOIN: begin
          if (!flags[idx]) begin
            flags[idx] <= 1'b1;
            idx        <= '0;
            cnt        <= '0;
            state      <= S_COUNT;
          end else if (idx == '0) begin
            err   <= 1'b1;
            cnt   <= '0;
            state <= S_COUNT;
          end else begin
            idx <= idx - SLOT_W'(1);
          end
        end

        // occupancy count over the slots in use
        S_COUNT: begin
          cnt <= cnt + CNT_W'(flags[idx]);
          if (idx == last) begin
            state <= S_DONE;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_answer <= answer_sel;
            out_akind  <= akind;
            out_cnt    <= cnt;
            out_err    <= err;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready            = (state == S_IDLE);
  assign result.valid          = out_valid;
  assign result.answer         = out_answer;
  assign result.answer_kind    = out_akind;
  assign result.occupied_count = out_cnt;
  assign result.error          = out_err;
endmodule
`default_nettype wire
